// ===== hdl/sca_pkg.sv =====
package sca_pkg;

	// Pool geometry
	localparam int unsigned ADDR_W        = 20;
	localparam int unsigned PAGE_BYTES    = 4096;
	localparam int unsigned GRANULE_BYTES = 128;
	localparam int unsigned MAX_PAGES     = 256;
	localparam int unsigned PAGE_W        = $clog2(PAGE_BYTES);
	localparam int unsigned GRAN_W        = $clog2(GRANULE_BYTES);
	localparam int unsigned LINK_DEPTH    = MAX_PAGES * PAGE_BYTES / GRANULE_BYTES;
	localparam int unsigned IDX_W         = $clog2(LINK_DEPTH);
	localparam int unsigned PAGES_W       = 9;
	localparam int unsigned SIZE_W        = 16;

	// Size classes
	localparam int unsigned NUM_CLASSES = 3;
	localparam int unsigned CLS_W       = 2;
	localparam int unsigned BYTES_W     = 11;
	localparam logic [BYTES_W-1:0] CLASS_BYTES [NUM_CLASSES] = '{
		BYTES_W'(128), BYTES_W'(256), BYTES_W'(512)
	};

	typedef logic [CLS_W-1:0]  cls_t;
	typedef logic [IDX_W-1:0]  idx_t;
	typedef logic [ADDR_W-1:0] addr_t;

	typedef enum logic {
		CMD_ALLOC = 1'b0,
		CMD_FREE  = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		STS_OK        = 2'd0,
		STS_OUT_POOL  = 2'd1,
		STS_TOO_LARGE = 2'd2,
		STS_NULL_FREE = 2'd3
	} status_t;

endpackage

// ===== hdl/sca_ram.sv =====
module sca_ram #(
	parameter int unsigned WIDTH = 13,
	parameter int unsigned DEPTH = 8192
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hdl/size_class_block_allocator.sv =====
// Size-class block allocator. Hands out 128, 256 and 512 byte blocks from a
// pool of 4 KB pages; a request goes to the smallest class that holds it.
// Each class keeps a LIFO free list linked through an 8192-entry link RAM
// (one entry per 128-byte granule). With an empty list a class carves its
// current page in ascending order, then takes the next unused page. In
// S_IDLE the block captures an item and reads the link RAM at the class
// head; in S_EXEC it uses the registered read data to pop or writes the
// link entry to push, and loads the result register. The result register
// frees the input side: a new item is taken while a result still waits,
// and a stalled result holds S_EXEC until it drains.
// Writing pool_pages (saturated to 256) empties all lists and restarts
// page handout at page zero; write it only while the block is idle.
// Status: 0 ok, 1 out of pool, 2 request over 512 bytes, 3 free of a null
// pointer. granted_address is 0 for every free and every failed allocate.
module size_class_block_allocator
	import sca_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,

	input  logic                pool_pages_we,
	input  logic [PAGES_W-1:0]  pool_pages_wdata,

	input  logic                req_valid,
	output logic                req_stall,
	input  logic                command,
	input  logic [SIZE_W-1:0]   request_size,
	input  logic [ADDR_W-1:0]   block_address,
	input  logic                address_valid,

	output logic                rsp_valid,
	input  logic                rsp_stall,
	output logic [ADDR_W-1:0]   granted_address,
	output logic [1:0]          status
);

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	state_t             state_q;

	// Pool state
	logic [PAGES_W-1:0] pool_pages_q;
	logic [PAGES_W-1:0] next_page_q;
	idx_t               head_q       [NUM_CLASSES];
	logic               head_valid_q [NUM_CLASSES];
	addr_t              carve_q      [NUM_CLASSES];
	logic               carve_valid_q[NUM_CLASSES];

	// Captured item
	cmd_t               cmd_s1;
	cls_t               cls_s1;
	logic               too_large_s1;
	logic               null_s1;
	idx_t               idx_s1;

	// Result register
	logic               rsp_valid_q;
	addr_t              granted_q;
	status_t            status_q;

	// Class decode of the incoming item
	cls_t               in_cls;
	logic               in_too_large;
	logic               accept;
	logic               done;

	// Link RAM
	logic               ram_we;
	idx_t               ram_waddr;
	idx_t               ram_wdata;
	logic               ram_re;
	idx_t               ram_raddr;
	idx_t               ram_rdata;

	// Execute-stage helpers
	addr_t              carve_src;
	logic               carve_end;
	addr_t              carve_next;
	logic [PAGES_W-1:0] pool_sat;

	always_comb begin
		in_too_large = 1'b0;
		if (request_size <= SIZE_W'(CLASS_BYTES[0])) begin
			in_cls = CLS_W'(0);
		end else if (request_size <= SIZE_W'(CLASS_BYTES[1])) begin
			in_cls = CLS_W'(1);
		end else if (request_size <= SIZE_W'(CLASS_BYTES[2])) begin
			in_cls = CLS_W'(2);
		end else begin
			in_cls       = CLS_W'(0);
			in_too_large = 1'b1;
		end
	end

	assign req_stall = (state_q != S_IDLE);
	assign accept    = req_valid && !req_stall;
	// Finish the execute cycle only when the result register can take the transfer;
	// hold it during a pool restart
	assign done      = (state_q == S_EXEC) && (!rsp_valid_q || !rsp_stall) && !pool_pages_we;

	// Read the head link of the class at capture time
	assign ram_re    = accept && (command == CMD_ALLOC) && !in_too_large;
	assign ram_raddr = head_q[in_cls];

	// Push: link the freed block to the old head, or to itself if the list is empty
	assign ram_we    = done && (cmd_s1 == CMD_FREE) && !null_s1 && !too_large_s1;
	assign ram_waddr = idx_s1;
	assign ram_wdata = head_valid_q[cls_s1] ? head_q[cls_s1] : idx_s1;

	sca_ram #(
		.WIDTH (IDX_W),
		.DEPTH (LINK_DEPTH)
	) u_link_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Carve source: the open page, else the first byte of the next page
	always_comb begin
		if (carve_valid_q[cls_s1]) begin
			carve_src = carve_q[cls_s1];
		end else begin
			carve_src = ADDR_W'(next_page_q) << PAGE_W;
		end
		// The page is used up when another block would not fit after this one
		carve_end  = ((ADDR_W'(carve_src[PAGE_W-1:0]) + (ADDR_W'(CLASS_BYTES[cls_s1]) << 1))
			> ADDR_W'(PAGE_BYTES));
		carve_next = carve_src + ADDR_W'(CLASS_BYTES[cls_s1]);
	end

	assign pool_sat = (pool_pages_wdata > PAGES_W'(MAX_PAGES)) ?
		PAGES_W'(MAX_PAGES) : pool_pages_wdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			rsp_valid_q  <= 1'b0;
			pool_pages_q <= PAGES_W'(MAX_PAGES);
			next_page_q  <= '0;
			for (int c = 0; c < NUM_CLASSES; c++) begin
				head_valid_q[c]  <= 1'b0;
				carve_valid_q[c] <= 1'b0;
			end
		end else begin
			// Drop the result after its transfer unless a new one replaces it
			if (rsp_valid_q && !rsp_stall && !done) begin
				rsp_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						cmd_s1       <= cmd_t'(command);
						cls_s1       <= in_cls;
						too_large_s1 <= in_too_large;
						null_s1      <= !address_valid;
						idx_s1       <= block_address[ADDR_W-1:GRAN_W];
						state_q      <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (done) begin
						state_q     <= S_IDLE;
						rsp_valid_q <= 1'b1;
						if (cmd_s1 == CMD_FREE) begin
							granted_q <= '0;
							if (null_s1) begin
								status_q <= STS_NULL_FREE;
							end else if (too_large_s1) begin
								status_q <= STS_TOO_LARGE;
							end else begin
								status_q             <= STS_OK;
								head_q[cls_s1]       <= idx_s1;
								head_valid_q[cls_s1] <= 1'b1;
							end
						end else if (too_large_s1) begin
							granted_q <= '0;
							status_q  <= STS_TOO_LARGE;
						end else if (head_valid_q[cls_s1]) begin
							// Pop; a self link ends the list
							granted_q <= {head_q[cls_s1], GRAN_W'(0)};
							status_q  <= STS_OK;
							if (ram_rdata == head_q[cls_s1]) begin
								head_valid_q[cls_s1] <= 1'b0;
							end else begin
								head_q[cls_s1] <= ram_rdata;
							end
						end else if (carve_valid_q[cls_s1] || (next_page_q < pool_pages_q)) begin
							granted_q <= carve_src;
							status_q  <= STS_OK;
							if (!carve_valid_q[cls_s1]) begin
								next_page_q <= next_page_q + PAGES_W'(1);
							end
							carve_valid_q[cls_s1] <= !carve_end;
							carve_q[cls_s1]       <= carve_next;
						end else begin
							granted_q <= '0;
							status_q  <= STS_OUT_POOL;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase

			// Restart the pool on a register write
			if (pool_pages_we) begin
				pool_pages_q <= pool_sat;
				next_page_q  <= '0;
				for (int c = 0; c < NUM_CLASSES; c++) begin
					head_valid_q[c]  <= 1'b0;
					carve_valid_q[c] <= 1'b0;
				end
			end
		end
	end

	assign rsp_valid       = rsp_valid_q;
	assign granted_address = granted_q;
	assign status          = status_q;

	// One item in flight: a transfer always closes the input for the next cycle
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> req_stall)
		else $error("input taken while an item is in flight");

	// A finished execute cycle always leaves a result in the register
	a_exec_result: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> rsp_valid)
		else $error("execute cycle finished without a result");

	// Granted blocks are granule aligned
	a_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (granted_address[GRAN_W-1:0] == '0))
		else $error("granted address not granule aligned");

	// Page handout never passes the pool size
	a_page_bound: assert property (@(posedge clk) disable iff (!arst_n)
		next_page_q <= pool_pages_q)
		else $error("next page beyond pool size");

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
	import sca_pkg::*;

	// Quiet cycles (no transfer on either channel) before the run is declared hung
	localparam int unsigned QUIET_LIMIT  = 2000;
	// Extra cycles after the last response, enough to expose a stray response
	localparam int unsigned DRAIN_CYCLES = 16;
	// Keep the generator only a few requests ahead so frees see recent grants
	localparam int unsigned PENDING_MAX  = 4;

	typedef struct {
		cmd_t                command;
		logic [SIZE_W-1:0]   size;
		addr_t               addr;
		logic                addr_valid;
	} pool_req_t;

	typedef struct {
		addr_t   addr;
		status_t status;
	} grant_t;

	// A block the allocator has handed out, with the class it came from
	typedef struct {
		addr_t addr;
		int    cls;
	} held_blk_t;

	logic                clk;
	logic                arst_n           = 1'b0;
	logic                pool_pages_we    = 1'b0;
	logic [PAGES_W-1:0]  pool_pages_wdata = '0;
	logic                req_valid        = 1'b0;
	logic                req_stall;
	logic                command          = 1'b0;
	logic [SIZE_W-1:0]   request_size     = '0;
	logic [ADDR_W-1:0]   block_address    = '0;
	logic                address_valid    = 1'b0;
	logic                rsp_valid;
	logic                rsp_stall        = 1'b0;
	logic [ADDR_W-1:0]   granted_address;
	logic [1:0]          status;

	size_class_block_allocator u_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.pool_pages_we    (pool_pages_we),
		.pool_pages_wdata (pool_pages_wdata),
		.req_valid        (req_valid),
		.req_stall        (req_stall),
		.command          (command),
		.request_size     (request_size),
		.block_address    (block_address),
		.address_valid    (address_valid),
		.rsp_valid        (rsp_valid),
		.rsp_stall        (rsp_stall),
		.granted_address  (granted_address),
		.status           (status)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Allocator shadow state: link per granule, per-class list head and
	// carve pointer, page handout counter and the saturated pool size.
	// ------------------------------------------------------------------
	idx_t               link_mem   [LINK_DEPTH];
	idx_t               head_idx   [NUM_CLASSES];
	bit                 head_ok    [NUM_CLASSES];
	addr_t              carve_addr [NUM_CLASSES];
	bit                 carve_ok   [NUM_CLASSES];
	logic [PAGES_W-1:0] pages_used;
	logic [PAGES_W-1:0] pages_limit;

	pool_req_t   pending_reqs    [$];
	grant_t      expected_grants [$];
	held_blk_t   held_blocks     [$];
	int unsigned mismatch_count = 0;

	// Smallest class that holds the size, -1 when it is over the largest class
	function automatic int size_class(input logic [SIZE_W-1:0] sz);
		for (int k = 0; k < NUM_CLASSES; k++)
			if (sz <= CLASS_BYTES[k])
				return k;
		return -1;
	endfunction

	// Restart the pool: empty every list and carve, hand out pages from zero
	function automatic void set_pool_model(input logic [PAGES_W-1:0] value);
		pages_limit = (value > MAX_PAGES) ? PAGES_W'(MAX_PAGES) : value;
		pages_used  = '0;
		for (int k = 0; k < NUM_CLASSES; k++) begin
			head_ok[k]    = 1'b0;
			head_idx[k]   = '0;
			carve_ok[k]   = 1'b0;
			carve_addr[k] = '0;
		end
		held_blocks.delete();
	endfunction

	// Move the carve of a class past the block just handed out; drop it when
	// the next block would not fit in the same page
	function automatic void step_carve(input int c, input addr_t a);
		int unsigned sz;
		int unsigned base;
		int unsigned nxt;
		sz   = CLASS_BYTES[c];
		base = a - (a % PAGE_BYTES);
		nxt  = a + sz;
		if (nxt - base + sz > PAGE_BYTES) begin
			carve_ok[c] = 1'b0;
		end else begin
			carve_addr[c] = addr_t'(nxt);
			carve_ok[c]   = 1'b1;
		end
	endfunction

	// Work out the response to one accepted request and advance the shadow
	function automatic grant_t predict_grant(input pool_req_t r);
		grant_t g;
		int     c;
		idx_t   gi;
		idx_t   nx;
		g.addr   = '0;
		g.status = STS_OK;
		c        = size_class(r.size);
		if (r.command == CMD_FREE) begin
			// null check wins over the size check
			if (!r.addr_valid) begin
				g.status = STS_NULL_FREE;
			end else if (c < 0) begin
				g.status = STS_TOO_LARGE;
			end else begin
				// truncate to the granule; push even if never allocated
				gi          = r.addr[ADDR_W-1:GRAN_W];
				link_mem[gi] = head_ok[c] ? head_idx[c] : gi;
				head_idx[c] = gi;
				head_ok[c]  = 1'b1;
			end
		end else if (c < 0) begin
			g.status = STS_TOO_LARGE;
		end else if (head_ok[c]) begin
			// pop; a self link ends the list
			gi     = head_idx[c];
			nx     = link_mem[gi];
			g.addr = {gi, {GRAN_W{1'b0}}};
			if (nx == gi)
				head_ok[c] = 1'b0;
			else
				head_idx[c] = nx;
		end else if (carve_ok[c]) begin
			g.addr = carve_addr[c];
			step_carve(c, g.addr);
		end else if (pages_used < pages_limit) begin
			g.addr     = addr_t'(pages_used * PAGE_BYTES);
			pages_used = pages_used + 1'b1;
			step_carve(c, g.addr);
		end else begin
			g.status = STS_OUT_POOL;
		end
		if (r.command == CMD_ALLOC && g.status == STS_OK)
			held_blocks.push_back('{addr: g.addr, cls: c});
		return g;
	endfunction

	// ------------------------------------------------------------------
	// Request generation
	// ------------------------------------------------------------------
	function automatic pool_req_t mk_req(input cmd_t cmd, input int unsigned sz,
			input int unsigned a, input bit v);
		pool_req_t r;
		r.command    = cmd;
		r.size       = SIZE_W'(sz);
		r.addr       = addr_t'(a);
		r.addr_valid = v;
		return r;
	endfunction

	// Random size that lands in the given class, edges favored
	function automatic logic [SIZE_W-1:0] size_in_class(input int c);
		int unsigned lo;
		int unsigned hi;
		lo = 0;
		if (c > 0)
			lo = CLASS_BYTES[c-1] + 1;
		hi = CLASS_BYTES[c];
		case ($urandom_range(7, 0))
			0:       return SIZE_W'(lo);
			1:       return SIZE_W'(hi);
			default: return SIZE_W'($urandom_range(hi, lo));
		endcase
	endfunction

	function automatic logic [SIZE_W-1:0] oversize();
		case ($urandom_range(3, 0))
			0:       return SIZE_W'(CLASS_BYTES[NUM_CLASSES-1] + 1);
			1:       return '1;
			default: return SIZE_W'($urandom_range(65535, 513));
		endcase
	endfunction

	// Mostly allocations and frees of blocks actually held, the rest broken
	// requests: null frees, oversize, stray addresses and wrong-class frees
	function automatic pool_req_t gen_random_req(input int unsigned alloc_pct);
		pool_req_t   r;
		int unsigned roll;
		int unsigned pick;
		held_blk_t   blk;
		// fields an allocate ignores still get random content
		r.command    = CMD_ALLOC;
		r.size       = size_in_class($urandom_range(NUM_CLASSES - 1, 0));
		r.addr       = addr_t'($urandom);
		r.addr_valid = 1'($urandom);
		roll         = $urandom_range(99, 0);
		if (roll < 12) begin
			r.command    = CMD_FREE;
			r.addr_valid = 1'b1;
			case ($urandom_range(4, 0))
				0: begin
					r.addr_valid = 1'b0;
					r.size       = SIZE_W'($urandom);
				end
				1: r.size = oversize();
				2: begin
					r.command = CMD_ALLOC;
					r.size    = oversize();
				end
				3: ;
				default: begin
					if (held_blocks.size() != 0) begin
						pick   = $urandom_range(held_blocks.size() - 1, 0);
						blk    = held_blocks[pick];
						r.addr = blk.addr;
						r.size = size_in_class((blk.cls + 1 + $urandom_range(1, 0)) % NUM_CLASSES);
					end
				end
			endcase
		end else if (held_blocks.size() != 0 && roll >= 12 + alloc_pct * 88 / 100) begin
			pick         = $urandom_range(held_blocks.size() - 1, 0);
			blk          = held_blocks[pick];
			r.command    = CMD_FREE;
			r.addr_valid = 1'b1;
			r.addr       = blk.addr;
			r.size       = size_in_class(blk.cls);
			// misaligned pointer into the same granule
			if ($urandom_range(7, 0) == 0)
				r.addr = blk.addr + addr_t'($urandom_range(127, 1));
			// keep an occasional block around so it gets freed twice
			if ($urandom_range(15, 0) != 0)
				held_blocks.delete(pick);
		end
		return r;
	endfunction

	task automatic queue_req(input pool_req_t r);
		while (pending_reqs.size() >= PENDING_MAX)
			@(posedge clk);
		pending_reqs.push_back(r);
	endtask

	task automatic wait_idle();
		while (pending_reqs.size() != 0 || req_valid || expected_grants.size() != 0)
			@(posedge clk);
	endtask

	// Write the pool size only with nothing in flight
	task automatic write_pool_pages(input logic [PAGES_W-1:0] value);
		wait_idle();
		@(posedge clk);
		pool_pages_we    <= 1'b1;
		pool_pages_wdata <= value;
		set_pool_model(value);
		@(posedge clk);
		pool_pages_we <= 1'b0;
	endtask

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		$display("[%0t] MISMATCH %s", $time, msg);
	endtask

	// ------------------------------------------------------------------
	// Request driver: bursts of random length with random gaps. A transfer
	// happens at an edge with valid high and stall low; hold the payload
	// while stalled, advance to the next pending request otherwise.
	// ------------------------------------------------------------------
	pool_req_t   cur_req;
	int unsigned burst_left = 8;
	int unsigned gap_left   = 0;

	always @(posedge clk) begin : driver
		if (arst_n) begin
			if (req_valid && !req_stall)
				expected_grants.push_back(predict_grant(cur_req));
			if (!req_valid || !req_stall) begin
				if (gap_left != 0) begin
					gap_left--;
					req_valid <= 1'b0;
				end else if (pending_reqs.size() != 0) begin
					cur_req        = pending_reqs.pop_front();
					req_valid     <= 1'b1;
					command       <= cur_req.command;
					request_size  <= cur_req.size;
					block_address <= cur_req.addr;
					address_valid <= cur_req.addr_valid;
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						// long bursts give stretches without any idling
						burst_left = ($urandom_range(4, 0) == 0) ? $urandom_range(80, 40)
							: $urandom_range(20, 1);
						case ($urandom_range(9, 0))
							0, 1, 2: gap_left = 0;
							3:       gap_left = $urandom_range(25, 10);
							default: gap_left = $urandom_range(6, 1);
						endcase
					end
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Response monitor: compare each transfer with the oldest expectation,
	// then pick the next stall value from the current stall pattern.
	// ------------------------------------------------------------------
	int unsigned stall_mode = 0;
	int unsigned mode_left  = 0;

	always @(posedge clk) begin : monitor
		grant_t want;
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				if (expected_grants.size() == 0) begin
					report_mismatch($sformatf("response with none expected: addr %h status %0d",
						granted_address, status));
				end else begin
					want = expected_grants.pop_front();
					if (granted_address !== want.addr)
						report_mismatch($sformatf("granted_address got %h want %h",
							granted_address, want.addr));
					if (status !== want.status)
						report_mismatch($sformatf("status got %0d want %0d (%s)",
							status, want.status, want.status.name()));
				end
			end
			if (mode_left == 0) begin
				stall_mode = $urandom_range(3, 0);
				mode_left  = $urandom_range(60, 8);
			end
			mode_left--;
			case (stall_mode)
				0:       rsp_stall <= 1'b0;
				1:       rsp_stall <= 1'($urandom);
				2:       rsp_stall <= ($urandom_range(3, 0) != 0);
				default: rsp_stall <= ~rsp_stall;
			endcase
		end
	end

	// Hang detector: end the run after too many cycles without a transfer
	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("[%0t] no transfer for %0d cycles", $time, QUIET_LIMIT);
		$display("size_class_block_allocator verification failed");
		$finish;
	end

	// ------------------------------------------------------------------
	// Stimulus: directed sequence on the reset pool, then random phases on
	// a range of pool sizes, small pools to reach exhaustion.
	// ------------------------------------------------------------------
	initial begin : stimulus
		logic [PAGES_W-1:0] phase_pages [5];
		int unsigned        phase_items [5];
		int unsigned        phase_alloc [5];
		phase_pages = '{9'd1, 9'd3, 9'd511, 9'd2, 9'd256};
		phase_items = '{150, 200, 200, 150, 170};
		phase_alloc = '{65, 60, 55, 70, 50};

		set_pool_model(PAGES_W'(MAX_PAGES));
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// class edges; each class takes its own page
		queue_req(mk_req(CMD_ALLOC, 0, 0, 1'b0));
		queue_req(mk_req(CMD_ALLOC, 128, 'hFFFFF, 1'b1));
		queue_req(mk_req(CMD_ALLOC, 129, 0, 1'b0));
		queue_req(mk_req(CMD_ALLOC, 256, 0, 1'b1));
		queue_req(mk_req(CMD_ALLOC, 257, 0, 1'b0));
		queue_req(mk_req(CMD_ALLOC, 512, 0, 1'b0));
		// oversize allocate
		queue_req(mk_req(CMD_ALLOC, 513, 0, 1'b1));
		queue_req(mk_req(CMD_ALLOC, 65535, 'hFFFFF, 1'b0));
		// null free takes precedence over oversize, then oversize free
		queue_req(mk_req(CMD_FREE, 65535, 'hFFFFF, 1'b0));
		queue_req(mk_req(CMD_FREE, 513, 0, 1'b1));
		// LIFO order, with a misaligned pointer
		queue_req(mk_req(CMD_FREE, 100, 0, 1'b1));
		queue_req(mk_req(CMD_FREE, 1, 128 + 37, 1'b1));
		queue_req(mk_req(CMD_ALLOC, 64, 0, 1'b0));
		queue_req(mk_req(CMD_ALLOC, 64, 0, 1'b0));
		// free the top address, in a page not yet handed out, then free it again at the head
		queue_req(mk_req(CMD_FREE, 512, 'hFFFFF, 1'b1));
		queue_req(mk_req(CMD_FREE, 400, 'hFFFFF, 1'b1));
		queue_req(mk_req(CMD_ALLOC, 300, 0, 1'b0));
		queue_req(mk_req(CMD_ALLOC, 300, 0, 1'b0));
		// class 1 block returned through class 0
		queue_req(mk_req(CMD_FREE, 10, 4096, 1'b1));
		queue_req(mk_req(CMD_ALLOC, 1, 0, 1'b0));

		// empty pool: only freed blocks can be handed out
		write_pool_pages('0);
		queue_req(mk_req(CMD_ALLOC, 200, 0, 1'b0));
		queue_req(mk_req(CMD_FREE, 200, 'h12380, 1'b1));
		queue_req(mk_req(CMD_ALLOC, 200, 0, 1'b0));
		queue_req(mk_req(CMD_ALLOC, 200, 0, 1'b0));
		repeat (30)
			queue_req(gen_random_req(50));

		for (int p = 0; p < 5; p++) begin
			write_pool_pages(phase_pages[p]);
			repeat (phase_items[p])
				queue_req(gen_random_req(phase_alloc[p]));
		end

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("size_class_block_allocator verification clean");
		else
			$display("size_class_block_allocator verification failed");
		$finish;
	end

endmodule
